### hdl/hfbs_pkg.sv
package hfbs_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = ADDR_W + 1;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [15:0] TX_DELAY_RESET = 16'd50;

   typedef enum logic [1:0] {
      FN_LOAD  = 2'd0,
      FN_START = 2'd1,
      FN_TICK  = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BUSY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_FLAGS = 3'd1,
      PH_DATA  = 3'd2,
      PH_CRCLO = 3'd3,
      PH_CRCHI = 3'd4,
      PH_CLOSE = 3'd5
   } phase_type;

   typedef enum logic {
      CTL_WAIT = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       load_byte;
      logic       start;
      logic       shift;
      logic       crc_step;
      logic       flag_dec;
      logic       next_byte;
      logic       clear;
      logic       tick_idle;
      phase_type  phase;
      logic       stuffing_off;
      logic       keyed;
      logic       frame_last;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     wrap;
      logic     flags_zero;
      logic     last_byte;
      logic     count_full;
      logic     count_zero;
   } dp_sts_type;

endpackage

### hdl/hfbs_datapath.sv
module hfbs_datapath
   import hfbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_write,
   input  logic [15:0] csr_tx_delay,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   output logic        rsp_tx_bit,
   output logic        rsp_stuffing_off,
   output logic        rsp_keyed,
   output logic        rsp_frame_last,
   output logic [1:0]  rsp_status
);

   logic [7:0]        store [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   func_type          func_ff;
   logic [7:0]        data_ff;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [ADDR_W-1:0] read_index_ff, read_index_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic [15:0]       flags_left_ff, flags_left_in;
   logic [15:0]       crc_ff, crc_in;
   logic [15:0]       tx_delay_ff, tx_delay_in;
   logic [7:0]        cur_byte;
   logic              frame_bit;
   logic              tx_bit_in;
   logic              crc_low;

   // Payload capture and store access.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         data_ff <= req_data_byte;
      end
      if (cmd.load_byte) begin
         store[byte_count_ff[ADDR_W-1:0]] <= data_ff;
      end
      rd_data_ff <= store[read_index_ff];
   end

   always_comb begin
      case (cmd.phase)
         PH_DATA:  cur_byte = rd_data_ff;
         PH_CRCLO: cur_byte = crc_ff[7:0] ^ BYTE_ONES;
         PH_CRCHI: cur_byte = crc_ff[15:8] ^ BYTE_ONES;
         default:  cur_byte = FLAG_BYTE;
      endcase
      frame_bit = cur_byte[bit_index_ff];

      if (cmd.tick_idle) begin
         tx_bit_in = 1'b1;
      end else if (cmd.shift) begin
         tx_bit_in = frame_bit;
      end else begin
         tx_bit_in = 1'b0;
      end

      byte_count_in = byte_count_ff;
      read_index_in = read_index_ff;
      bit_index_in  = bit_index_ff;
      flags_left_in = flags_left_ff;
      crc_in        = crc_ff;
      tx_delay_in   = csr_write ? csr_tx_delay : tx_delay_ff;

      crc_low = crc_ff[0] ^ frame_bit;

      if (cmd.load_byte) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         flags_left_in = tx_delay_ff;
         bit_index_in  = 3'd0;
         read_index_in = '0;
         crc_in        = CRC_INIT;
      end
      if (cmd.shift) begin
         bit_index_in = bit_index_ff + 3'd1;
      end
      if (cmd.crc_step) begin
         crc_in = {1'b0, crc_ff[15:1]} ^ (crc_low ? CRC_POLY : 16'h0000);
      end
      if (cmd.flag_dec) begin
         flags_left_in = flags_left_ff - 16'd1;
      end
      if (cmd.next_byte) begin
         read_index_in = read_index_ff + ADDR_W'(1);
      end
      if (cmd.clear) begin
         byte_count_in = '0;
         read_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         read_index_ff <= '0;
         bit_index_ff  <= 3'd0;
         flags_left_ff <= 16'd0;
         crc_ff        <= CRC_INIT;
         tx_delay_ff   <= TX_DELAY_RESET;
      end else begin
         byte_count_ff <= byte_count_in;
         read_index_ff <= read_index_in;
         bit_index_ff  <= bit_index_in;
         flags_left_ff <= flags_left_in;
         crc_ff        <= crc_in;
         tx_delay_ff   <= tx_delay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_tx_bit       <= tx_bit_in;
         rsp_stuffing_off <= cmd.stuffing_off;
         rsp_keyed        <= cmd.keyed;
         rsp_frame_last   <= cmd.frame_last;
         rsp_status       <= cmd.status;
      end
   end

   assign sts.func       = func_ff;
   assign sts.wrap       = (bit_index_ff == 3'd7);
   assign sts.flags_zero = (flags_left_ff == 16'd0);
   assign sts.last_byte  = ({1'b0, read_index_ff} + CNT_W'(1)) >= byte_count_ff;
   assign sts.count_full = (byte_count_ff == CNT_W'(STORE_DEPTH));
   assign sts.count_zero = (byte_count_ff == '0);

endmodule

### hdl/hfbs_controller.sv
module hfbs_controller
   import hfbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;
   logic          exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_WAIT;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign exec      = (state_ff == CTL_EXEC) && slot_free;
   assign req_stall = (state_ff != CTL_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.phase    = phase_ff;
      cmd.status   = ST_OK;

      case (state_ff)
         CTL_WAIT: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (exec) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_WAIT;
               case (sts.func)
                  FN_LOAD: begin
                     if (phase_ff != PH_IDLE) begin
                        cmd.status = ST_BUSY;
                     end else if (sts.count_full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.load_byte = 1'b1;
                     end
                     cmd.keyed = (phase_ff != PH_IDLE);
                  end
                  FN_START: begin
                     if (phase_ff != PH_IDLE) begin
                        cmd.status = ST_BUSY;
                     end else if (sts.count_zero) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.start = 1'b1;
                        phase_in  = PH_FLAGS;
                     end
                     cmd.keyed = (phase_in != PH_IDLE);
                  end
                  FN_TICK: begin
                     if (phase_ff == PH_IDLE) begin
                        cmd.tick_idle = 1'b1;
                     end else begin
                        cmd.keyed = 1'b1;
                        cmd.shift = 1'b1;
                        case (phase_ff)
                           PH_FLAGS: begin
                              cmd.stuffing_off = 1'b1;
                              if (sts.wrap) begin
                                 if (sts.flags_zero) begin
                                    phase_in = PH_DATA;
                                 end else begin
                                    cmd.flag_dec = 1'b1;
                                 end
                              end
                           end
                           PH_DATA: begin
                              cmd.crc_step = 1'b1;
                              if (sts.wrap) begin
                                 if (sts.last_byte) begin
                                    phase_in = PH_CRCLO;
                                 end else begin
                                    cmd.next_byte = 1'b1;
                                 end
                              end
                           end
                           PH_CRCLO: begin
                              if (sts.wrap) begin
                                 phase_in = PH_CRCHI;
                              end
                           end
                           PH_CRCHI: begin
                              if (sts.wrap) begin
                                 phase_in = PH_CLOSE;
                              end
                           end
                           default: begin
                              cmd.stuffing_off = 1'b1;
                              if (sts.wrap) begin
                                 cmd.frame_last = 1'b1;
                                 cmd.clear      = 1'b1;
                                 phase_in       = PH_IDLE;
                              end
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = CTL_WAIT;
         end
      endcase
   end

   // A frame in flight always has at least one payload byte behind it.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> !sts.count_zero)
      else $error("frame in progress with an empty store");

   assert property (@(posedge clock) disable iff (reset)
      cmd.frame_last |=> (phase_ff == PH_IDLE) && sts.count_zero)
      else $error("closing flag did not return the block to idle");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.exec) |=> (phase_ff == PH_FLAGS) && sts.wrap == 1'b0)
      else $error("accepted start did not arm the opening flags");

   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff && (state_ff == CTL_WAIT))
      else $error("executed transaction did not produce a result");

endmodule

### hdl/hdlc_frame_bit_serializer.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// req      | req_valid/req_stall  | req_func, req_data_byte
// rsp      | rsp_valid/rsp_stall  | rsp_tx_bit, rsp_stuffing_off, rsp_keyed,
//          |                      | rsp_frame_last, rsp_status
// csr      | csr_valid/csr_ready  | csr_tx_delay
//
// Each transaction is captured in the wait state and executed in the exec state,
// which loads the result register.
// The store read port is registered.
// A stalled result holds execution of the next transaction, one in flight.
// Synchronous reset clears the controller and counters and presets the CRC; the store
// is not cleared, since only written entries are ever read. csr_ready is always high.
module hdlc_frame_bit_serializer
   import hfbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_bit,
   output logic        rsp_stuffing_off,
   output logic        rsp_keyed,
   output logic        rsp_frame_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_tx_delay
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   hfbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hfbs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .csr_write        (csr_valid && csr_ready),
      .csr_tx_delay     (csr_tx_delay),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_tx_bit       (rsp_tx_bit),
      .rsp_stuffing_off (rsp_stuffing_off),
      .rsp_keyed        (rsp_keyed),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_status       (rsp_status)
   );

endmodule
